// ----- rtl/core/evt_pkg.sv -----
// ----------------------------------------------------------------------------
// evt_pkg: shared definitions of the event timer
// Register map, request codes, field widths and the word structs.
// ----------------------------------------------------------------------------
`default_nettype none

package evt_pkg;

   localparam int NUM_TIMERS_DEF = 3;
   localparam int ROUTE_BITS_DEF = 5;

   localparam int DATA_W      = 64;
   localparam int ADDR_W      = 6;
   localparam int MASK_W      = 3;
   localparam int PERIOD_W    = 27;
   localparam int ROUTE_CAP_W = 32;
   localparam int ROUTE_IDX_W = $clog2(ROUTE_CAP_W);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [ADDR_W-1:0] ADDR_CAPS       = 6'h00;
   localparam logic [ADDR_W-1:0] ADDR_GCFG       = 6'h02;
   localparam logic [ADDR_W-1:0] ADDR_STATUS     = 6'h04;
   localparam logic [ADDR_W-1:0] ADDR_COUNTER    = 6'h1E;
   localparam logic [ADDR_W-1:0] ADDR_TIMER_BASE = 6'h20;

   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUTE_MASK    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIODIC_MASK = 2'd2;

   localparam logic [PERIOD_W-1:0]    PERIOD_RESET        = 27'd69841279;
   localparam logic [ROUTE_CAP_W-1:0] ROUTE_MASK_RESET    = '1;
   localparam logic [MASK_W-1:0]      PERIODIC_MASK_RESET = '1;

   localparam logic [7:0] CAPS_REVISION = 8'h01;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2,
      REQ_NOP   = 2'd3
   } req_code_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } item_type;

   typedef struct packed {
      logic [DATA_W-1:0] rdata;
      logic [MASK_W-1:0] fire_mask;
      logic [MASK_W-1:0] irq_pending_mask;
   } result_type;

   typedef struct packed {
      logic [PERIOD_W-1:0]    period_fs;
      logic [ROUTE_CAP_W-1:0] route_mask;
      logic [MASK_W-1:0]      periodic_mask;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/core/evt_ifs.sv -----
// ----------------------------------------------------------------------------
// evt_ifs: request and response channels
// Valid/ready channels carrying request words and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface evt_req_if
   import evt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [ADDR_W-1:0] addr;
   logic [DATA_W-1:0] wdata;

   modport source (output valid, req_type, addr, wdata, input ready);
   modport sink   (input valid, req_type, addr, wdata, output ready);
endinterface

interface evt_rsp_if
   import evt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] rdata;
   logic [MASK_W-1:0] fire_mask;
   logic [MASK_W-1:0] irq_pending_mask;

   modport source (output valid, rdata, fire_mask, irq_pending_mask, input ready);
   modport sink   (input valid, rdata, fire_mask, irq_pending_mask, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/evt_core.sv -----
// ----------------------------------------------------------------------------
// evt_core: timer state and single-pass update
// Holds counter, comparators, periods and timer control; decodes one word
// and commits the new state when commit is high.
// ----------------------------------------------------------------------------
`default_nettype none

module evt_core
   import evt_pkg::*;
#(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF,
   parameter int ROUTE_BITS = ROUTE_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       commit,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output      result_type res
);

   localparam int TSEL_W = ADDR_W - 2;

   logic [1:0]            gen_ff, gen_in;
   logic [DATA_W-1:0]     counter_ff, counter_in;
   logic [NUM_TIMERS-1:0] status_ff, status_in;
   logic [DATA_W-1:0]     comp_ff [NUM_TIMERS];
   logic [DATA_W-1:0]     comp_in [NUM_TIMERS];
   logic [DATA_W-1:0]     period_ff [NUM_TIMERS];
   logic [DATA_W-1:0]     period_in [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] int_en_ff, int_en_in;
   logic [NUM_TIMERS-1:0] periodic_ff, periodic_in;
   logic [NUM_TIMERS-1:0] valset_ff, valset_in;
   logic [ROUTE_BITS-1:0] route_ff [NUM_TIMERS];
   logic [ROUTE_BITS-1:0] route_in [NUM_TIMERS];

   logic [NUM_TIMERS-1:0]  pcap;
   logic [NUM_TIMERS-1:0]  fire;
   logic [DATA_W-1:0]      counter_inc;
   logic [DATA_W-1:0]      rdata;
   logic [ADDR_W-1:0]      off;
   logic [TSEL_W-1:0]      tsel;
   logic                   timer_hit;
   logic                   is_cfg;
   logic [ROUTE_BITS-1:0]  want;
   logic [ROUTE_IDX_W-1:0] want_idx;
   logic                   route_ok;
   logic                   is_tick, is_read, is_write;

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_pcap
      if (g < MASK_W) begin : g_cap
         assign pcap[g] = cfg.periodic_mask[g];
      end else begin : g_nocap
         assign pcap[g] = 1'b0;
      end
   end

   assign is_tick  = item.req_type == REQ_TICK;
   assign is_read  = item.req_type == REQ_READ;
   assign is_write = item.req_type == REQ_WRITE;

   assign off       = item.addr - ADDR_TIMER_BASE;
   assign tsel      = off[ADDR_W-1:2];
   assign timer_hit = (item.addr >= ADDR_TIMER_BASE) && !off[1];
   assign is_cfg    = !off[0];
   assign want      = item.wdata[9 +: ROUTE_BITS];
   assign want_idx  = ROUTE_IDX_W'(want);
   assign route_ok  = cfg.route_mask[want_idx];

   assign counter_inc = counter_ff + DATA_W'(1);

   always_comb begin
      gen_in      = gen_ff;
      counter_in  = counter_ff;
      status_in   = status_ff;
      comp_in     = comp_ff;
      period_in   = period_ff;
      int_en_in   = int_en_ff;
      periodic_in = periodic_ff;
      valset_in   = valset_ff;
      route_in    = route_ff;
      fire        = '0;
      rdata       = '0;

      if (is_tick && gen_ff[0]) begin
         counter_in = counter_inc;
         for (int n = 0; n < NUM_TIMERS; n++) begin
            if (counter_inc == comp_ff[n]) begin
               if (int_en_ff[n]) begin
                  status_in[n] = 1'b1;
                  fire[n]      = 1'b1;
               end
               if (periodic_ff[n] && pcap[n]) begin
                  comp_in[n] = comp_ff[n] + period_ff[n];
               end
            end
         end
      end

      if (is_read) begin
         unique case (item.addr)
            ADDR_CAPS: begin
               rdata[32 +: PERIOD_W] = cfg.period_fs;
               rdata[15]             = 1'b1;
               rdata[13]             = 1'b1;
               rdata[12:8]           = 5'(NUM_TIMERS - 1);
               rdata[7:0]            = CAPS_REVISION;
            end
            ADDR_GCFG:    rdata = DATA_W'(gen_ff);
            ADDR_STATUS:  rdata = DATA_W'(status_ff);
            ADDR_COUNTER: rdata = counter_ff;
            default: begin
               for (int n = 0; n < NUM_TIMERS; n++) begin
                  if (timer_hit && int'(tsel) == n) begin
                     if (is_cfg) begin
                        rdata[63:32]            = cfg.route_mask;
                        rdata[9 +: ROUTE_BITS]  = route_ff[n];
                        rdata[6]                = valset_ff[n];
                        rdata[5]                = 1'b1;
                        rdata[4]                = pcap[n];
                        rdata[3]                = periodic_ff[n] && pcap[n];
                        rdata[2]                = int_en_ff[n];
                     end else begin
                        rdata = comp_ff[n];
                     end
                  end
               end
            end
         endcase
      end

      if (is_write) begin
         unique case (item.addr)
            ADDR_GCFG:    gen_in = item.wdata[1:0];
            ADDR_STATUS:  status_in = status_ff & ~item.wdata[NUM_TIMERS-1:0];
            ADDR_COUNTER: counter_in = item.wdata;
            default: begin
               for (int n = 0; n < NUM_TIMERS; n++) begin
                  if (timer_hit && int'(tsel) == n) begin
                     if (is_cfg) begin
                        int_en_in[n]   = item.wdata[2];
                        periodic_in[n] = item.wdata[3];
                        valset_in[n]   = item.wdata[6];
                        if (route_ok) begin
                           route_in[n] = want;
                        end
                     end else if (!(periodic_ff[n] && pcap[n])) begin
                        comp_in[n] = item.wdata;
                     end else if (valset_ff[n]) begin
                        comp_in[n]   = item.wdata;
                        period_in[n] = item.wdata;
                        valset_in[n] = 1'b0;
                     end else begin
                        period_in[n] = item.wdata;
                     end
                  end
               end
            end
         endcase
      end
   end

   assign res.rdata            = rdata;
   assign res.fire_mask        = MASK_W'(fire);
   assign res.irq_pending_mask = MASK_W'(status_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff      <= '0;
         counter_ff  <= '0;
         status_ff   <= '0;
         int_en_ff   <= '0;
         periodic_ff <= '0;
         valset_ff   <= '0;
         for (int n = 0; n < NUM_TIMERS; n++) begin
            comp_ff[n]   <= '1;
            period_ff[n] <= '0;
            route_ff[n]  <= '0;
         end
      end else if (commit) begin
         gen_ff      <= gen_in;
         counter_ff  <= counter_in;
         status_ff   <= status_in;
         comp_ff     <= comp_in;
         period_ff   <= period_in;
         int_en_ff   <= int_en_in;
         periodic_ff <= periodic_in;
         valset_ff   <= valset_in;
         route_ff    <= route_in;
      end
   end

   a_fire_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      commit && !is_tick |-> res.fire_mask == '0)
      else $error("fire on a word that is not a tick");

   a_counter_advance: assert property (@(posedge clock) disable iff (reset)
      commit && is_tick && gen_ff[0] |=> counter_ff == $past(counter_inc))
      else $error("counter missed a tick");

   a_status_clear: assert property (@(posedge clock) disable iff (reset)
      commit && is_write && item.addr == ADDR_STATUS
      |=> (status_ff & $past(item.wdata[NUM_TIMERS-1:0])) == '0)
      else $error("status bits not cleared by write");

endmodule

`default_nettype wire

// ----- rtl/core/event_timer_with_comparators_unit.sv -----
// ----------------------------------------------------------------------------
// event_timer_with_comparators_unit: event timer with comparators
// Valid/ready request and response channels around the timer core.
// ----------------------------------------------------------------------------
// Each request word is a counter tick, a register read or a register write
// (64-bit register words, index in addr). Every request word gives exactly
// one response word: read data, the timers that fired on a tick, and the
// interrupt status after the word.
// A request word is taken into an input register, processed in one pass of
// the core logic and its response captured in the output register: with the
// output free, one word per cycle is sustained.
// When the receiver stalls, the response register holds and the input
// register keeps one more word; ready drops only when both are full.
// Configuration (tick period, route mask, periodic mask) is written by the user
// through the csr_ port only while no word is in flight; the block does not enforce it.
// Reset empties both registers and brings the timer state to its defaults:
// counter halted at zero, comparators all ones, periods and control zero.
// ----------------------------------------------------------------------------
`default_nettype none

module event_timer_with_comparators_unit
   import evt_pkg::*;
#(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF,
   parameter int ROUTE_BITS = ROUTE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   evt_req_if.sink                     req_if,
   evt_rsp_if.source                   rsp_if,
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff;
   item_type   item_ff;
   logic       s1_valid_ff, s1_valid_in;
   result_type result_ff;
   result_type res;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_accept;

   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !s1_valid_ff || advance;
   assign req_accept    = req_if.valid && req_if.ready;
   assign s1_valid_in   = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_fs     <= PERIOD_RESET;
         cfg_ff.route_mask    <= ROUTE_MASK_RESET;
         cfg_ff.periodic_mask <= PERIODIC_MASK_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_PERIOD:        cfg_ff.period_fs     <= csr_wdata[PERIOD_W-1:0];
            CSR_ROUTE_MASK:    cfg_ff.route_mask    <= csr_wdata[ROUTE_CAP_W-1:0];
            CSR_PERIODIC_MASK: cfg_ff.periodic_mask <= csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.req_type <= req_if.req_type;
         item_ff.addr     <= req_if.addr;
         item_ff.wdata    <= req_if.wdata;
      end
      if (advance) begin
         result_ff <= res;
      end
   end

   evt_core #(
      .NUM_TIMERS (NUM_TIMERS),
      .ROUTE_BITS (ROUTE_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .res    (res)
   );

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.rdata            = result_ff.rdata;
   assign rsp_if.fire_mask        = result_ff.fire_mask;
   assign rsp_if.irq_pending_mask = result_ff.irq_pending_mask;

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(item_ff))
      else $error("stalled request word lost");

   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_accept && s1_valid_ff |-> advance)
      else $error("request word accepted over a held word");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed word has no response");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: event timer with comparators, self-checking bench
// Drives tick, read and write words through the request channel, predicts
// every response word from a local copy of the timer state and compares it
// field by field, across several tick period, route and periodic settings
// and three handshake pacing modes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
   import evt_pkg::*;
();

   localparam int NTMR        = NUM_TIMERS_DEF;
   localparam int RBITS       = ROUTE_BITS_DEF;
   localparam int NUM_SEGS    = 6;
   localparam int SEG_WORDS   = 290;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TMR_STRIDE  = 4;

   // timer control bits, local layout
   localparam int CTL_INT_EN   = 0;
   localparam int CTL_PERIODIC = 1;
   localparam int CTL_VALSET   = 2;
   localparam int CTL_ROUTE    = 3;

   // timer config word bits
   localparam int WR_INT_EN   = 2;
   localparam int WR_PERIODIC = 3;
   localparam int WR_VALSET   = 6;
   localparam int WR_ROUTE    = 9;

   logic clock;
   logic reset;
   logic                   csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   evt_req_if req_if ();
   evt_rsp_if rsp_if ();

   event_timer_with_comparators_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predicted timer state
   logic [PERIOD_W-1:0]    cfg_period;
   logic [ROUTE_CAP_W-1:0] cfg_route;
   logic [MASK_W-1:0]      cfg_periodic;
   logic [1:0]             tmr_enable;
   logic [DATA_W-1:0]      tick_count;
   logic [DATA_W-1:0]      cmp_val [NTMR];
   logic [DATA_W-1:0]      per_val [NTMR];
   logic [7:0]             tctl    [NTMR];
   logic [MASK_W-1:0]      irq_status;

   item_type   stim_words [$];
   result_type due_responses [$];
   item_type   cur_word;

   int send_idle_pct;
   int recv_idle_pct;
   int fail_count;
   int words_sent;
   int fire_ticks;
   int words_queued;
   int cycle_count;

   function automatic result_type timer_predict(input item_type w);
      result_type r;
      logic [ADDR_W-1:0] ofs;
      int unsigned tn;
      logic is_cfg;
      logic [RBITS-1:0] want;
      logic [RBITS-1:0] route;
      int i;
      r = '0;
      ofs = w.addr - ADDR_TIMER_BASE;
      tn = NTMR;
      is_cfg = 1'b0;
      if (w.addr >= ADDR_TIMER_BASE && ofs[1] == 1'b0) begin
         tn = 32'(ofs[ADDR_W-1:2]);
         is_cfg = (ofs[0] == 1'b0);
      end
      case (w.req_type)
         REQ_TICK: begin
            if (tmr_enable[0]) begin
               tick_count = tick_count + 64'd1;
               for (i = 0; i < NTMR; i++) begin
                  if (tick_count == cmp_val[i]) begin
                     if (tctl[i][CTL_INT_EN]) begin
                        irq_status[i] = 1'b1;
                        r.fire_mask[i] = 1'b1;
                     end
                     if (tctl[i][CTL_PERIODIC] && cfg_periodic[i])
                        cmp_val[i] = cmp_val[i] + per_val[i];
                  end
               end
            end
         end
         REQ_READ: begin
            if (w.addr == ADDR_CAPS)
               r.rdata = {32'(cfg_period), 16'h0, 3'b101, 5'(NTMR - 1), CAPS_REVISION};
            else if (w.addr == ADDR_GCFG)
               r.rdata = 64'(tmr_enable);
            else if (w.addr == ADDR_STATUS)
               r.rdata = 64'(irq_status);
            else if (w.addr == ADDR_COUNTER)
               r.rdata = tick_count;
            else if (tn < NTMR) begin
               if (is_cfg)
                  r.rdata = {cfg_route, 18'd0, tctl[tn][CTL_ROUTE +: RBITS], 2'b00,
                             tctl[tn][CTL_VALSET], 1'b1, cfg_periodic[tn],
                             tctl[tn][CTL_PERIODIC] & cfg_periodic[tn],
                             tctl[tn][CTL_INT_EN], 2'b00};
               else
                  r.rdata = cmp_val[tn];
            end
         end
         REQ_WRITE: begin
            if (w.addr == ADDR_GCFG)
               tmr_enable = w.wdata[1:0];
            else if (w.addr == ADDR_STATUS)
               irq_status = irq_status & ~w.wdata[MASK_W-1:0];
            else if (w.addr == ADDR_COUNTER)
               tick_count = w.wdata;
            else if (tn < NTMR) begin
               if (is_cfg) begin
                  want = w.wdata[WR_ROUTE +: RBITS];
                  route = cfg_route[want] ? want : tctl[tn][CTL_ROUTE +: RBITS];
                  tctl[tn] = {route, w.wdata[WR_VALSET], w.wdata[WR_PERIODIC],
                              w.wdata[WR_INT_EN]};
               end else if (!(tctl[tn][CTL_PERIODIC] && cfg_periodic[tn])) begin
                  cmp_val[tn] = w.wdata;
               end else if (tctl[tn][CTL_VALSET]) begin
                  cmp_val[tn] = w.wdata;
                  per_val[tn] = w.wdata;
                  tctl[tn][CTL_VALSET] = 1'b0;
               end else begin
                  per_val[tn] = w.wdata;
               end
            end
         end
         default: ;
      endcase
      r.irq_pending_mask = irq_status;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] tmr_addr(input int t, input bit is_cmp);
      return ADDR_TIMER_BASE + ADDR_W'(TMR_STRIDE * t + int'(is_cmp));
   endfunction

   function automatic logic [ADDR_W-1:0] any_reg_addr();
      int unsigned k;
      k = $urandom_range(9);
      case (k)
         0: return ADDR_CAPS;
         1: return ADDR_GCFG;
         2: return ADDR_STATUS;
         3: return ADDR_COUNTER;
         default: return tmr_addr((k - 4) / 2, ((k - 4) % 2) == 1);
      endcase
   endfunction

   task automatic queue_word(input logic [1:0] rt, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d);
      item_type w;
      w.req_type = rt;
      w.addr = a;
      w.wdata = d;
      stim_words.push_back(w);
      words_queued++;
   endtask

   task automatic queue_timer_cfg(input int t);
      logic [DATA_W-1:0] cfgw;
      cfgw = {$urandom, $urandom};
      cfgw[WR_INT_EN] = ($urandom_range(3) != 0);
      cfgw[WR_PERIODIC] = 1'($urandom_range(1));
      cfgw[WR_VALSET] = ($urandom_range(9) < 7);
      queue_word(REQ_WRITE, tmr_addr(t, 1'b0), cfgw);
   endtask

   // program counter and timers near a base, then run ticks past the comparators
   task automatic queue_scenario();
      logic [DATA_W-1:0] base;
      int t;
      int k;
      int n_run;
      int pick;
      if ($urandom_range(3) == 0)
         base = 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(15));
      else
         base = {$urandom, $urandom};
      queue_word(REQ_WRITE, ADDR_COUNTER, base);
      if ($urandom_range(9) == 0)
         queue_word(REQ_WRITE, ADDR_GCFG, {$urandom, $urandom} & ~64'h1);
      else
         queue_word(REQ_WRITE, ADDR_GCFG, {$urandom, $urandom} | 64'h1);
      for (t = 0; t < NTMR; t++) begin
         if ($urandom_range(4) != 0) begin
            queue_timer_cfg(t);
            queue_word(REQ_WRITE, tmr_addr(t, 1'b1), base + 64'($urandom_range(1, 10)));
            if ($urandom_range(1) == 1)
               queue_word(REQ_WRITE, tmr_addr(t, 1'b1), 64'($urandom_range(1, 6)));
         end
      end
      n_run = $urandom_range(6, 30);
      for (k = 0; k < n_run; k++) begin
         pick = $urandom_range(99);
         if (pick < 70)
            queue_word(REQ_TICK, ADDR_W'($urandom), {$urandom, $urandom});
         else if (pick < 82)
            queue_word(REQ_READ, any_reg_addr(), {$urandom, $urandom});
         else if (pick < 90)
            queue_word(REQ_WRITE, ADDR_STATUS, {$urandom, $urandom});
         else if (pick < 95)
            queue_word(REQ_NOP, ADDR_W'($urandom), {$urandom, $urandom});
         else
            queue_timer_cfg($urandom_range(NTMR - 1));
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_PERIOD:        cfg_period = val[PERIOD_W-1:0];
         CSR_ROUTE_MASK:    cfg_route = val[ROUTE_CAP_W-1:0];
         CSR_PERIODIC_MASK: cfg_periodic = val[MASK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drain_words();
      do @(negedge clock);
      while (stim_words.size() != 0 || req_if.valid || due_responses.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            due_responses.push_back(timer_predict(cur_word));
            words_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (stim_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_word = stim_words.pop_front();
               req_if.valid <= 1'b1;
               req_if.req_type <= cur_word.req_type;
               req_if.addr <= cur_word.addr;
               req_if.wdata <= cur_word.wdata;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_check
      result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_responses.size() == 0) begin
               $error("response word with nothing expected");
               fail_count++;
            end else begin
               want = due_responses.pop_front();
               if (want.fire_mask != 0)
                  fire_ticks++;
               if (rsp_if.rdata !== want.rdata) begin
                  $error("rdata: expected %h, got %h", want.rdata, rsp_if.rdata);
                  fail_count++;
               end
               if (rsp_if.fire_mask !== want.fire_mask) begin
                  $error("fire_mask: expected %b, got %b", want.fire_mask, rsp_if.fire_mask);
                  fail_count++;
               end
               if (rsp_if.irq_pending_mask !== want.irq_pending_mask) begin
                  $error("irq_pending_mask: expected %b, got %b",
                         want.irq_pending_mask, rsp_if.irq_pending_mask);
                  fail_count++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      int seg;
      int t;
      int n;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.req_type = REQ_NOP;
      req_if.addr = '0;
      req_if.wdata = '0;
      rsp_if.ready = 1'b0;
      csr_wen = 1'b0;
      csr_index = CSR_PERIOD;
      csr_wdata = '0;
      fail_count = 0;
      words_sent = 0;
      fire_ticks = 0;
      words_queued = 0;
      cycle_count = 0;
      send_idle_pct = 18;
      recv_idle_pct = 47;
      cfg_period = PERIOD_RESET;
      cfg_route = ROUTE_MASK_RESET;
      cfg_periodic = PERIODIC_MASK_RESET;
      tmr_enable = '0;
      tick_count = '0;
      irq_status = '0;
      for (t = 0; t < NTMR; t++) begin
         cmp_val[t] = '1;
         per_val[t] = '0;
         tctl[t] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // register map, unknown words, wrap and periodic reload
      queue_word(REQ_READ, ADDR_CAPS, '0);
      queue_word(REQ_READ, ADDR_GCFG, '0);
      queue_word(REQ_READ, ADDR_STATUS, '0);
      queue_word(REQ_READ, ADDR_COUNTER, '0);
      queue_word(REQ_READ, tmr_addr(0, 1'b0), '0);
      queue_word(REQ_READ, tmr_addr(2, 1'b1), '0);
      queue_word(REQ_READ, 6'h3F, '1);
      queue_word(REQ_READ, tmr_addr(NTMR, 1'b0), '0);
      queue_word(REQ_NOP, ADDR_CAPS, '1);
      queue_word(REQ_TICK, ADDR_CAPS, '0);
      queue_word(REQ_WRITE, ADDR_CAPS, '1);
      queue_word(REQ_WRITE, ADDR_COUNTER, 64'hFFFF_FFFF_FFFF_FFFE);
      queue_word(REQ_WRITE, ADDR_GCFG, 64'h3);
      queue_word(REQ_WRITE, tmr_addr(0, 1'b0),
                 (64'd1 << WR_INT_EN) | (64'd1 << WR_PERIODIC) | (64'd1 << WR_VALSET) |
                 (64'd31 << WR_ROUTE));
      queue_word(REQ_WRITE, tmr_addr(0, 1'b1), 64'd0);
      queue_word(REQ_WRITE, tmr_addr(0, 1'b1), 64'd5);
      queue_word(REQ_WRITE, tmr_addr(1, 1'b0), '1);
      queue_word(REQ_WRITE, tmr_addr(1, 1'b1), '1);
      queue_word(REQ_TICK, '1, '1);
      queue_word(REQ_TICK, '0, '0);
      queue_word(REQ_READ, tmr_addr(0, 1'b0), '0);
      queue_word(REQ_READ, tmr_addr(0, 1'b1), '0);
      queue_word(REQ_WRITE, ADDR_STATUS, '1);
      queue_word(REQ_WRITE, tmr_addr(NTMR, 1'b1), '1);
      queue_word(REQ_READ, ADDR_GCFG, '0);

      for (seg = 0; seg < NUM_SEGS; seg++) begin
         if (seg > 0) begin
            drain_words();
            case (seg)
               1: begin
                  write_csr(CSR_PERIOD, 32'd1);
                  write_csr(CSR_ROUTE_MASK, 32'h0);
                  write_csr(CSR_PERIODIC_MASK, 32'h0);
               end
               2: begin
                  write_csr(CSR_PERIOD, 32'd100000000);
                  write_csr(CSR_ROUTE_MASK, 32'hFFFF_FFFF);
                  write_csr(CSR_PERIODIC_MASK, 32'h7);
               end
               3: begin
                  write_csr(CSR_PERIOD, $urandom_range(1, 100000000));
                  write_csr(CSR_ROUTE_MASK, $urandom);
                  write_csr(CSR_PERIODIC_MASK, $urandom_range(7));
               end
               4: begin
                  write_csr(CSR_PERIOD, $urandom_range(1, 100000000));
                  write_csr(CSR_ROUTE_MASK, $urandom & $urandom);
                  write_csr(CSR_PERIODIC_MASK, $urandom_range(7));
               end
               default: begin
                  write_csr(CSR_PERIOD, 32'(PERIOD_RESET));
                  write_csr(CSR_ROUTE_MASK, ROUTE_MASK_RESET);
                  write_csr(CSR_PERIODIC_MASK, 32'(PERIODIC_MASK_RESET));
               end
            endcase
         end
         case (seg / 2)
            0: begin
               send_idle_pct = 18;
               recv_idle_pct = 47;
            end
            1: begin
               send_idle_pct = 47;
               recv_idle_pct = 18;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         words_queued = 0;
         while (words_queued < SEG_WORDS) begin
            if ($urandom_range(4) != 0) begin
               queue_scenario();
            end else begin
               n = $urandom_range(1, 3);
               repeat (n)
                  queue_word(2'($urandom_range(3)), ADDR_W'($urandom_range(63)),
                             {$urandom, $urandom});
            end
         end
      end

      drain_words();
      repeat (8) @(posedge clock);
      $display("Checked %0d words over %0d register settings and three pacing modes.",
               words_sent, NUM_SEGS);
      $display("%0d ticks fired a timer; %0d mismatches.", fire_ticks, fail_count);
      if (fail_count == 0 && due_responses.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
